FILE: hw/rtl/prq_pkg.sv
package prq_pkg;

    // Commands carried in the cmd field of an input item.
    localparam logic [2:0] CMD_CREATE   = 3'd0;
    localparam logic [2:0] CMD_PUSH     = 3'd1;
    localparam logic [2:0] CMD_POP      = 3'd2;
    localparam logic [2:0] CMD_SET      = 3'd3;
    localparam logic [2:0] CMD_SCHEDULE = 3'd4;

    // Task status codes.
    localparam logic [1:0] ST_INACTIVE = 2'd0;
    localparam logic [1:0] ST_ACTIVE   = 2'd1;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] task_id;
        logic [7:0] priority_req;
        logic [1:0] status_value;
    } in_item_t;

    typedef struct packed {
        logic [5:0] result_task;
        logic       queue_was_empty;
        logic       refused;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_C_SCAN,
        S_C_WRITE,
        S_P_PRIO,
        S_ENQ,
        S_E_SCAN,
        S_SHIFT,
        S_INSERT,
        S_POP_HEAD,
        S_POP_ID,
        S_POP_CHK,
        S_RESP
    } state_t;

endpackage

FILE: hw/rtl/prq_task_mem.sv
// Per-task status and priority store. Status entries carry valid bits so that
// an entry never written reads as inactive.
module prq_task_mem
    import prq_pkg::*;
#(
    parameter int NUM_TASKS = 64,
    parameter int TW        = 6,
    parameter int PRIO_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [TW-1:0]        rd_addr,
    output logic [1:0]           rd_status,
    output logic [PRIO_BITS-1:0] rd_prio,
    input  logic                 wr_en,
    input  logic [TW-1:0]        wr_addr,
    input  logic [1:0]           wr_status,
    input  logic                 wr_prio_en,
    input  logic [PRIO_BITS-1:0] wr_prio
);

    logic [1:0]           status_mem [NUM_TASKS];
    logic [PRIO_BITS-1:0] prio_mem   [NUM_TASKS];
    logic [NUM_TASKS-1:0] valid_reg;
    logic [1:0]           rd_status_reg;
    logic [PRIO_BITS-1:0] rd_prio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            status_mem[wr_addr] <= wr_status;
        end
        if (wr_en && wr_prio_en)
        begin
            prio_mem[wr_addr] <= wr_prio;
        end
        rd_status_reg <= valid_reg[rd_addr] ? status_mem[rd_addr] : ST_INACTIVE;
        rd_prio_reg   <= prio_mem[rd_addr];
    end

    assign rd_status = rd_status_reg;
    assign rd_prio   = rd_prio_reg;

endmodule

FILE: hw/rtl/prq_queue_mem.sv
// Circular run queue storage: one write port, one registered read port.
module prq_queue_mem
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int QW          = 6,
    parameter int TW          = 6
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [QW-1:0] wr_addr,
    input  logic [TW-1:0] wr_data,
    input  logic [QW-1:0] rd_addr,
    output logic [TW-1:0] rd_data
);

    logic [TW-1:0] mem [QUEUE_DEPTH];
    logic [TW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/priority_run_queue_scheduler_core.sv
// Channel   Signals                      Direction  Content
// input     in_valid, in_ready, in_item  in         command, task, priority, status
// output    out_valid, out_ready, out_item out      result task, empty flag, refusal
//
// One item is handled at a time. Set status, unknown commands and commands refused
// at decode go from the decode state straight to the response state. Pop passes
// through the head, id and check states for each queue entry it removes. Insertion
// (create, push, the re-push of schedule) walks the queue from the head at one
// entry a cycle until it finds its place, then moves the tail back one entry a
// cycle; create first scans the task store at one slot a cycle. These walks over
// the queue and task memory ports set how long a create takes, and how long a pop
// or schedule that drains the queue takes. Reset is asynchronous and takes effect
// at once, with no clearing pass. A waiting result in the output register does not
// stop the next item from being taken; only its completion waits for the output
// to drain.
module priority_run_queue_scheduler_core
    import prq_pkg::*;
#(
    parameter int NUM_TASKS   = 64,
    parameter int QUEUE_DEPTH = 64,
    parameter int PRIO_BITS   = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int TW   = $clog2(NUM_TASKS);
    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int IW   = (TW + 1 > 6) ? TW + 1 : 6;
    localparam int RW   = (TW > 6) ? TW : 6;
    localparam int PEXT = (PRIO_BITS > 8) ? PRIO_BITS : 8;

    state_t               state_reg, state_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic [5:0]           tid_reg, tid_next;
    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [1:0]           want_reg, want_next;
    logic [QW-1:0]        head_reg, head_next;
    logic [QW:0]          cnt_reg, cnt_next;
    logic [PRIO_BITS-1:0] p_reg, p_next;
    logic [TW-1:0]        enq_id_reg, enq_id_next;
    logic [5:0]           res_reg, res_next;
    logic                 empty_reg, empty_next;
    logic                 refused_reg, refused_next;
    logic [QW:0]          pos_reg, pos_next;
    logic [QW:0]          qk_reg, qk_next;
    logic                 v1_reg, v1_next;
    logic [QW:0]          k1_reg, k1_next;
    logic                 v2_reg, v2_next;
    logic [QW:0]          k2_reg, k2_next;
    logic [QW:0]          sk_reg, sk_next;
    logic                 wv_reg, wv_next;
    logic [QW:0]          wk_reg, wk_next;
    logic [TW:0]          scan_reg, scan_next;
    logic                 pv_reg, pv_next;
    logic [TW-1:0]        pidx_reg, pidx_next;
    logic [TW-1:0]        cand_reg, cand_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;

    logic [TW-1:0]        tm_rd_addr;
    logic [1:0]           tm_rd_status;
    logic [PRIO_BITS-1:0] tm_rd_prio;
    logic                 tm_wr_en;
    logic [TW-1:0]        tm_wr_addr;
    logic [1:0]           tm_wr_status;
    logic                 tm_wr_prio_en;
    logic [QW-1:0]        qm_rd_addr;
    logic [TW-1:0]        qm_rd_data;
    logic                 qm_wr_en;
    logic [QW-1:0]        qm_wr_addr;
    logic [TW-1:0]        qm_wr_data;

    logic [IW-1:0]        tid_ext;
    logic                 tid_ok;
    logic                 q_full;
    logic [PEXT-1:0]      prio_in_ext;

    // Queue position relative to the head, wrapped around the buffer.
    function automatic logic [QW-1:0] qwrap(input logic [QW-1:0] base,
                                            input logic [QW:0] off);
        logic [QW+1:0] s;
        s = (QW+2)'(base) + (QW+2)'(off);
        if (s >= (QW+2)'(QUEUE_DEPTH))
        begin
            s = s - (QW+2)'(QUEUE_DEPTH);
        end
        return s[QW-1:0];
    endfunction

    function automatic logic [5:0] id6(input logic [TW-1:0] id);
        logic [RW-1:0] e;
        e = RW'(id);
        return e[5:0];
    endfunction

    prq_task_mem #(
        .NUM_TASKS (NUM_TASKS),
        .TW        (TW),
        .PRIO_BITS (PRIO_BITS)
    ) u_task_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_addr    (tm_rd_addr),
        .rd_status  (tm_rd_status),
        .rd_prio    (tm_rd_prio),
        .wr_en      (tm_wr_en),
        .wr_addr    (tm_wr_addr),
        .wr_status  (tm_wr_status),
        .wr_prio_en (tm_wr_prio_en),
        .wr_prio    (prio_reg)
    );

    prq_queue_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .QW          (QW),
        .TW          (TW)
    ) u_queue_mem (
        .clk     (clk),
        .wr_en   (qm_wr_en),
        .wr_addr (qm_wr_addr),
        .wr_data (qm_wr_data),
        .rd_addr (qm_rd_addr),
        .rd_data (qm_rd_data)
    );

    assign tid_ext     = IW'(tid_reg);
    assign tid_ok      = tid_ext < IW'(NUM_TASKS);
    assign q_full      = cnt_reg >= (QW+1)'(QUEUE_DEPTH);
    assign prio_in_ext = PEXT'(in_item.priority_req);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            tid_reg       <= '0;
            prio_reg      <= '0;
            want_reg      <= '0;
            head_reg      <= '0;
            cnt_reg       <= '0;
            p_reg         <= '0;
            enq_id_reg    <= '0;
            res_reg       <= '0;
            empty_reg     <= 1'b0;
            refused_reg   <= 1'b0;
            pos_reg       <= '0;
            qk_reg        <= '0;
            v1_reg        <= 1'b0;
            k1_reg        <= '0;
            v2_reg        <= 1'b0;
            k2_reg        <= '0;
            sk_reg        <= '0;
            wv_reg        <= 1'b0;
            wk_reg        <= '0;
            scan_reg      <= '0;
            pv_reg        <= 1'b0;
            pidx_reg      <= '0;
            cand_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            tid_reg       <= tid_next;
            prio_reg      <= prio_next;
            want_reg      <= want_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            p_reg         <= p_next;
            enq_id_reg    <= enq_id_next;
            res_reg       <= res_next;
            empty_reg     <= empty_next;
            refused_reg   <= refused_next;
            pos_reg       <= pos_next;
            qk_reg        <= qk_next;
            v1_reg        <= v1_next;
            k1_reg        <= k1_next;
            v2_reg        <= v2_next;
            k2_reg        <= k2_next;
            sk_reg        <= sk_next;
            wv_reg        <= wv_next;
            wk_reg        <= wk_next;
            scan_reg      <= scan_next;
            pv_reg        <= pv_next;
            pidx_reg      <= pidx_next;
            cand_reg      <= cand_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        tid_next       = tid_reg;
        prio_next      = prio_reg;
        want_next      = want_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        p_next         = p_reg;
        enq_id_next    = enq_id_reg;
        res_next       = res_reg;
        empty_next     = empty_reg;
        refused_next   = refused_reg;
        pos_next       = pos_reg;
        qk_next        = qk_reg;
        v1_next        = v1_reg;
        k1_next        = k1_reg;
        v2_next        = v2_reg;
        k2_next        = k2_reg;
        sk_next        = sk_reg;
        wv_next        = wv_reg;
        wk_next        = wk_reg;
        scan_next      = scan_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        cand_next      = cand_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        tm_rd_addr    = '0;
        tm_wr_en      = 1'b0;
        tm_wr_addr    = tid_ext[TW-1:0];
        tm_wr_status  = want_reg;
        tm_wr_prio_en = 1'b0;
        qm_rd_addr    = head_reg;
        qm_wr_en      = 1'b0;
        qm_wr_addr    = qwrap(head_reg, wk_reg);
        qm_wr_data    = qm_rd_data;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = in_item.cmd;
                    tid_next   = in_item.task_id;
                    prio_next  = prio_in_ext[PRIO_BITS-1:0];
                    want_next  = in_item.status_value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_next     = '0;
                empty_next   = 1'b0;
                refused_next = 1'b0;
                unique case (cmd_reg)
                    CMD_CREATE:
                    begin
                        if (q_full)
                        begin
                            refused_next = 1'b1;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            tm_rd_addr = '0;
                            pidx_next  = '0;
                            pv_next    = 1'b1;
                            scan_next  = (TW+1)'(1);
                            state_next = S_C_SCAN;
                        end
                    end
                    CMD_PUSH:
                    begin
                        res_next = tid_reg;
                        if (!tid_ok || q_full)
                        begin
                            refused_next = 1'b1;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            tm_rd_addr  = tid_ext[TW-1:0];
                            enq_id_next = tid_ext[TW-1:0];
                            state_next  = S_P_PRIO;
                        end
                    end
                    CMD_POP:
                    begin
                        state_next = S_POP_HEAD;
                    end
                    CMD_SCHEDULE:
                    begin
                        want_next  = ST_ACTIVE;
                        state_next = S_POP_HEAD;
                    end
                    CMD_SET:
                    begin
                        res_next   = tid_reg;
                        tm_wr_en   = tid_ok;
                        state_next = S_RESP;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            // Search for the lowest inactive slot, one read issued a cycle.
            S_C_SCAN:
            begin
                if (pv_reg && tm_rd_status == ST_INACTIVE)
                begin
                    enq_id_next = pidx_reg;
                    state_next  = S_C_WRITE;
                end
                else if (scan_reg < (TW+1)'(NUM_TASKS))
                begin
                    tm_rd_addr = scan_reg[TW-1:0];
                    pidx_next  = scan_reg[TW-1:0];
                    scan_next  = scan_reg + 1'b1;
                    pv_next    = 1'b1;
                end
                else
                begin
                    refused_next = 1'b1;
                    state_next   = S_RESP;
                end
            end

            S_C_WRITE:
            begin
                tm_wr_en      = 1'b1;
                tm_wr_addr    = enq_id_reg;
                tm_wr_status  = ST_ACTIVE;
                tm_wr_prio_en = 1'b1;
                p_next        = prio_reg;
                res_next      = id6(enq_id_reg);
                state_next    = S_ENQ;
            end

            S_P_PRIO:
            begin
                p_next     = tm_rd_prio;
                state_next = S_ENQ;
            end

            S_ENQ:
            begin
                if (cnt_reg == '0)
                begin
                    pos_next   = '0;
                    state_next = S_INSERT;
                end
                else
                begin
                    qm_rd_addr = head_reg;
                    qk_next    = (QW+1)'(1);
                    v1_next    = 1'b1;
                    k1_next    = '0;
                    v2_next    = 1'b0;
                    state_next = S_E_SCAN;
                end
            end

            // Two-stage walk: queue entry read, then that task's priority read.
            S_E_SCAN:
            begin
                if (v2_reg && tm_rd_prio > p_reg)
                begin
                    pos_next   = k2_reg;
                    sk_next    = cnt_reg;
                    wv_next    = 1'b0;
                    state_next = S_SHIFT;
                end
                else if (v2_reg && k2_reg == cnt_reg - 1'b1)
                begin
                    pos_next   = cnt_reg;
                    state_next = S_INSERT;
                end
                else
                begin
                    if (v1_reg)
                    begin
                        tm_rd_addr = qm_rd_data;
                        v2_next    = 1'b1;
                        k2_next    = k1_reg;
                    end
                    else
                    begin
                        v2_next = 1'b0;
                    end
                    if (qk_reg < cnt_reg)
                    begin
                        qm_rd_addr = qwrap(head_reg, qk_reg);
                        v1_next    = 1'b1;
                        k1_next    = qk_reg;
                        qk_next    = qk_reg + 1'b1;
                    end
                    else
                    begin
                        v1_next = 1'b0;
                    end
                end
            end

            // Move the tail back one place, from the end down to the insert point.
            S_SHIFT:
            begin
                qm_wr_en = wv_reg;
                if (sk_reg > pos_reg)
                begin
                    qm_rd_addr = qwrap(head_reg, sk_reg - 1'b1);
                    wv_next    = 1'b1;
                    wk_next    = sk_reg;
                    sk_next    = sk_reg - 1'b1;
                end
                else
                begin
                    wv_next = 1'b0;
                    if (!wv_reg)
                    begin
                        state_next = S_INSERT;
                    end
                end
            end

            S_INSERT:
            begin
                qm_wr_en   = 1'b1;
                qm_wr_addr = qwrap(head_reg, pos_reg);
                qm_wr_data = enq_id_reg;
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_RESP;
            end

            S_POP_HEAD:
            begin
                if (cnt_reg == '0)
                begin
                    res_next   = '0;
                    empty_next = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    qm_rd_addr = head_reg;
                    head_next  = qwrap(head_reg, (QW+1)'(1));
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_POP_ID;
                end
            end

            S_POP_ID:
            begin
                tm_rd_addr = qm_rd_data;
                cand_next  = qm_rd_data;
                state_next = S_POP_CHK;
            end

            S_POP_CHK:
            begin
                if (tm_rd_status == want_reg)
                begin
                    res_next = id6(cand_reg);
                    if (cmd_reg == CMD_SCHEDULE)
                    begin
                        enq_id_next = cand_reg;
                        p_next      = tm_rd_prio;
                        state_next  = S_ENQ;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    state_next = S_POP_HEAD;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_next.result_task     = res_reg;
                    out_next.queue_was_empty = empty_reg;
                    out_next.refused         = refused_reg;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The fill count never passes the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // An empty pop always reports the idle task.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.queue_was_empty |-> out_item.result_task == '0)
        else $error("empty result with non-idle task");

    // A result is never both refused and empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.refused && out_item.queue_was_empty))
        else $error("refused and empty together");

    // An accepted item is decoded in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DECODE)
        else $error("accepted item not decoded");
`endif

endmodule

FILE: tb/prq_checker.sv
module prq_checker
    import prq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_item,
    output int        fail_count,
    output int        pending_results,
    output int        pops_seen,
    output int        creates_seen
);

    // Shadow copy of the scheduler state.
    logic [5:0] run_queue [64];
    int         run_len;
    logic [1:0] status_of [64];
    logic [7:0] prio_of [64];
    out_item_t  expected_results [$];

    function automatic bit insert_sorted(input logic [5:0] id);
        int pos;
        pos = run_len;
        if (run_len >= 64)
            return 0;
        for (int k = 0; k < run_len; k++)
            if (prio_of[run_queue[k]] > prio_of[id])
            begin
                pos = k;
                break;
            end
        for (int k = run_len; k > pos; k--)
            run_queue[k] = run_queue[k - 1];
        run_queue[pos] = id;
        run_len++;
        return 1;
    endfunction

    function automatic bit take_matching(input logic [1:0] want, output logic [5:0] id);
        logic [5:0] head;
        id = '0;
        while (run_len > 0)
        begin
            head = run_queue[0];
            for (int k = 1; k < run_len; k++)
                run_queue[k - 1] = run_queue[k];
            run_len--;
            if (status_of[head] == want)
            begin
                id = head;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic out_item_t schedule_step(input in_item_t it);
        out_item_t  r;
        logic [5:0] t;
        r = '0;
        case (it.cmd)
            CMD_CREATE:
            begin
                r.refused = 1'b1;
                if (run_len < 64)
                    for (int i = 0; i < 64; i++)
                        if (status_of[i] == ST_INACTIVE)
                        begin
                            status_of[i] = ST_ACTIVE;
                            prio_of[i] = it.priority_req;
                            void'(insert_sorted(6'(i)));
                            r.result_task = 6'(i);
                            r.refused = 1'b0;
                            break;
                        end
            end
            CMD_PUSH:
            begin
                r.result_task = it.task_id;
                r.refused = !insert_sorted(it.task_id);
            end
            CMD_POP:
            begin
                r.queue_was_empty = !take_matching(it.status_value, t);
                r.result_task = t;
            end
            CMD_SET:
            begin
                r.result_task = it.task_id;
                status_of[it.task_id] = it.status_value;
            end
            CMD_SCHEDULE:
            begin
                if (take_matching(ST_ACTIVE, t))
                begin
                    void'(insert_sorted(t));
                    r.result_task = t;
                end
                else
                    r.queue_was_empty = 1'b1;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            pending_results = 0;
            pops_seen = 0;
            creates_seen = 0;
            run_len = 0;
            expected_results.delete();
            for (int i = 0; i < 64; i++)
            begin
                status_of[i] = ST_INACTIVE;
                prio_of[i] = '0;
            end
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result item with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    if (out_item.result_task !== want.result_task)
                        report_mismatch($sformatf("result_task %0d, expected %0d",
                                                  out_item.result_task, want.result_task));
                    if (out_item.queue_was_empty !== want.queue_was_empty)
                        report_mismatch($sformatf("queue_was_empty %0b, expected %0b",
                                                  out_item.queue_was_empty,
                                                  want.queue_was_empty));
                    if (out_item.refused !== want.refused)
                        report_mismatch($sformatf("refused %0b, expected %0b",
                                                  out_item.refused, want.refused));
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_item.cmd == CMD_POP || in_item.cmd == CMD_SCHEDULE)
                    pops_seen++;
                if (in_item.cmd == CMD_CREATE)
                    creates_seen++;
                expected_results.push_back(schedule_step(in_item));
            end
            pending_results = expected_results.size();
        end
    end

endmodule

FILE: tb/priority_run_queue_scheduler_core_tb.sv
module priority_run_queue_scheduler_core_tb;
    import prq_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;
    int        fail_count;
    int        pending_results;
    int        pops_seen;
    int        creates_seen;
    int        cycle_count = 0;

    // Idle rates in percent for the sender and the receiver.
    int send_idle_pct;
    int recv_idle_pct;

    // Shadow of which task slots have been created, so that a push never names a
    // task whose priority was never written.
    bit created_slot [64];
    int items_sent;

    // Commands in flight, oldest first, to pair results with their commands.
    logic [2:0] cmd_in_flight [$];

    localparam int CYCLE_LIMIT = 4000000;

    priority_run_queue_scheduler_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    prq_checker checker_inst
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_item        (out_item),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .pops_seen       (pops_seen),
        .creates_seen    (creates_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // The receiver stalls at random; its ready is redrawn on every rising edge.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // A cycle counter guards against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic bit last_cmd_is_create();
        return cmd_in_flight.size() > 0 && cmd_in_flight[0] == CMD_CREATE;
    endfunction

    // A slot becomes known as created when it appears in a create result. The
    // command of each result is looked up before the in-flight list moves on.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready && !out_item.refused && last_cmd_is_create())
                created_slot[out_item.result_task] = 1'b1;
            if (in_valid && in_ready)
                cmd_in_flight.push_back(in_item.cmd);
            if (out_valid && out_ready && cmd_in_flight.size() > 0)
                void'(cmd_in_flight.pop_front());
        end
    end

    // Sends one item: optional random idle cycles first, then valid is held
    // until the block accepts it.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Builds an item from its fields.
    function automatic in_item_t make_item(input logic [2:0] c, input logic [5:0] id,
                                           input logic [7:0] p, input logic [1:0] s);
        in_item_t it;
        it.cmd = c;
        it.task_id = id;
        it.priority_req = p;
        it.status_value = s;
        return it;
    endfunction

    // Chooses a random item. Pushes are restricted to created slots; the
    // other fields carry random values so that every bit is toggled.
    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        int       tries;
        it = make_item(3'($urandom_range(7)), 6'($urandom), 8'($urandom),
                       2'($urandom));
        pick = $urandom_range(99);
        if (pick < 22)
            it.cmd = CMD_CREATE;
        else if (pick < 42)
            it.cmd = CMD_PUSH;
        else if (pick < 60)
            it.cmd = CMD_POP;
        else if (pick < 75)
            it.cmd = CMD_SET;
        else if (pick < 96)
            it.cmd = CMD_SCHEDULE;
        // The remainder keeps the random command, unknown codes included.
        if (it.cmd == CMD_POP && $urandom_range(3) != 0)
            it.status_value = ST_ACTIVE;
        if (it.cmd == CMD_SET && $urandom_range(3) != 0)
            it.status_value = 2'($urandom_range(2));
        // Half the time priorities are squeezed into four values (0 to 3), so that ties and
        // round robin among equal priorities are common.
        if ($urandom_range(1) == 0)
            it.priority_req = 8'($urandom_range(3));
        if (it.cmd == CMD_PUSH)
        begin
            tries = 0;
            while (!created_slot[it.task_id] && tries < 200)
            begin
                it.task_id = 6'($urandom);
                tries++;
            end
            if (!created_slot[it.task_id])
                it.cmd = CMD_CREATE;
        end
        return it;
    endfunction

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        in_item_t it;
        items_sent    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty queue, extreme priorities, ties, status
        // changes, pops that drain mismatches, and unknown commands.
        send_item(make_item(CMD_POP, 6'd0, 8'd0, ST_ACTIVE));
        send_item(make_item(CMD_SCHEDULE, 6'd63, 8'd255, 2'd3));
        send_item(make_item(CMD_CREATE, 6'd0, 8'd255, 2'd0));
        send_item(make_item(CMD_CREATE, 6'd63, 8'd0, 2'd3));
        send_item(make_item(CMD_CREATE, 6'd21, 8'd0, 2'd1));
        send_item(make_item(CMD_CREATE, 6'd42, 8'd128, 2'd2));
        send_item(make_item(CMD_SCHEDULE, 6'd0, 8'd0, 2'd0));
        send_item(make_item(CMD_SCHEDULE, 6'd0, 8'd0, 2'd0));
        send_item(make_item(CMD_SET, 6'd1, 8'd0, 2'd2));
        send_item(make_item(CMD_SET, 6'd63, 8'd255, 2'd3));
        send_item(make_item(CMD_POP, 6'd0, 8'd0, 2'd2));
        send_item(make_item(CMD_PUSH, 6'd1, 8'd0, 2'd0));
        send_item(make_item(CMD_SET, 6'd2, 8'd0, 2'd3));
        send_item(make_item(CMD_CREATE, 6'd0, 8'd7, 2'd0));
        send_item(make_item(CMD_POP, 6'd0, 8'd0, 2'd3));
        send_item(make_item(CMD_POP, 6'd0, 8'd0, ST_INACTIVE));
        send_item(make_item(3'd5, 6'd63, 8'd255, 2'd3));
        send_item(make_item(3'd6, 6'd0, 8'd0, 2'd0));
        send_item(make_item(3'd7, 6'd42, 8'd85, 2'd1));
        drain();

        // Fill the queue to refusal: repeated pushes of one created task.
        for (int i = 0; i < 66; i++)
            send_item(make_item(CMD_PUSH, 6'd0, 8'd0, 2'd0));
        send_item(make_item(CMD_CREATE, 6'd0, 8'd9, 2'd0));
        send_item(make_item(CMD_POP, 6'd0, 8'd0, 2'd3));
        // Use up all slots, then one more create is refused for lack of a slot.
        for (int i = 0; i < 66; i++)
            send_item(make_item(CMD_CREATE, 6'd0, 8'($urandom), 2'd0));
        send_item(make_item(CMD_POP, 6'd0, 8'd0, 2'd3));
        drain();

        // Random part in three idling phases; the sender pauses for a full
        // drain at the end of each phase.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 7 : 0;
            for (int n = 0; n < 530; n++)
            begin
                it = random_item();
                send_item(it);
                // Occasionally free queue places up again by drain pops.
                if ($urandom_range(199) == 0)
                    send_item(make_item(CMD_POP, 6'd0, 8'd0, 2'd3));
            end
            drain();
        end

        $display("Ran %0d items: %0d creates, %0d pops or schedules,",
                 items_sent, creates_seen, pops_seen);
        $display("across three idle mixes with full drains between them.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
